### rtl/spq_pkg.sv
// Shared constants, codes and controller/datapath interface types for the sorted priority queue.
package spq_pkg;

   localparam int CAPACITY = 16;
   localparam int IDX_W    = $clog2(CAPACITY);
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int DATA_W   = 32;
   localparam int FILL_W   = 5;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_SERVE  = 1'b1;

   localparam logic [1:0] ST_INSERTED = 2'd0;
   localparam logic [1:0] ST_SERVED   = 2'd1;
   localparam logic [1:0] ST_EMPTY    = 2'd2;
   localparam logic [1:0] ST_FULL     = 2'd3;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic       capture;
      logic       rd_head;
      logic       rd_tail;
      logic       rd_prev;
      logic       wr_shift;
      logic       wr_new_next;
      logic       wr_new_head;
      logic       finish;
      logic [1:0] fin_status;
      logic       load_rsp;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic op_serve;
      logic is_empty;
      logic is_full;
      logic scan_go;
      logic cur_zero;
   } dp_stat_type;

endpackage

### rtl/spq_ctrl.sv
// Controller state machine that sequences insert scans, serves and result transfers.
module spq_ctrl import spq_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_START = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_PLACE = 3'd3;
   localparam logic [2:0] S_SERVE = 3'd4;
   localparam logic [2:0] S_DONE  = 3'd5;

   logic [2:0] state_ff;
   logic [2:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       out_free;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_START;
            end
         end
         S_START: begin
            if (stat.op_serve) begin
               if (stat.is_empty) begin
                  cmd.finish     = 1'b1;
                  cmd.fin_status = ST_EMPTY;
                  state_in       = S_DONE;
               end else begin
                  cmd.rd_head = 1'b1;
                  state_in    = S_SERVE;
               end
            end else if (stat.is_full) begin
               cmd.finish     = 1'b1;
               cmd.fin_status = ST_FULL;
               state_in       = S_DONE;
            end else if (stat.is_empty) begin
               cmd.wr_new_head = 1'b1;
               cmd.finish      = 1'b1;
               cmd.fin_status  = ST_INSERTED;
               state_in        = S_DONE;
            end else begin
               cmd.rd_tail = 1'b1;
               state_in    = S_SCAN;
            end
         end
         S_SCAN: begin
            if (stat.scan_go) begin
               cmd.wr_shift = 1'b1;
               if (stat.cur_zero) begin
                  state_in = S_PLACE;
               end else begin
                  cmd.rd_prev = 1'b1;
               end
            end else begin
               cmd.wr_new_next = 1'b1;
               cmd.finish      = 1'b1;
               cmd.fin_status  = ST_INSERTED;
               state_in        = S_DONE;
            end
         end
         S_PLACE: begin
            cmd.wr_new_head = 1'b1;
            cmd.finish      = 1'b1;
            cmd.fin_status  = ST_INSERTED;
            state_in        = S_DONE;
         end
         S_SERVE: begin
            cmd.finish     = 1'b1;
            cmd.fin_status = ST_SERVED;
            state_in       = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_scan_entry: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> ($past(state_ff) == S_START || $past(state_ff) == S_SCAN))
      else $error("scan state entered from an unexpected state");

   a_result_once: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_DONE && state_ff == S_IDLE))
      else $error("result presented outside the done state");
`endif

endmodule

### rtl/spq_datapath.sv
// Datapath with the entry memories, head pointer, entry count, scan index and result registers.
module spq_datapath import spq_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_opcode,
   input  logic signed [DATA_W-1:0] req_item_value,
   input  logic signed [DATA_W-1:0] req_item_priority,
   input  dp_cmd_type               cmd,
   output dp_stat_type              stat,
   output logic [1:0]               rsp_status,
   output logic signed [DATA_W-1:0] rsp_served_value,
   output logic [FILL_W-1:0]        rsp_fill_level
);

   // Entry memories, addressed physically; logical position 0 sits at head_ff.
   logic signed [DATA_W-1:0] val_mem_ff [CAPACITY];
   logic signed [DATA_W-1:0] pri_mem_ff [CAPACITY];

   logic                     op_ff;
   logic signed [DATA_W-1:0] new_val_ff;
   logic signed [DATA_W-1:0] new_pri_ff;
   logic signed [DATA_W-1:0] rd_val_ff;
   logic signed [DATA_W-1:0] rd_pri_ff;
   logic [IDX_W-1:0]         head_ff;
   logic [IDX_W-1:0]         head_in;
   logic [CNT_W-1:0]         count_ff;
   logic [CNT_W-1:0]         count_in;
   logic [IDX_W-1:0]         cur_ff;
   logic [IDX_W-1:0]         cur_in;
   logic [1:0]               res_status_ff;
   logic signed [DATA_W-1:0] res_value_ff;
   logic [1:0]               rsp_status_ff;
   logic signed [DATA_W-1:0] rsp_value_ff;
   logic [FILL_W-1:0]        rsp_fill_ff;

   logic                     rd_en;
   logic [IDX_W-1:0]         rd_addr;
   logic                     wr_en;
   logic [IDX_W-1:0]         wr_addr;
   logic signed [DATA_W-1:0] wr_val;
   logic signed [DATA_W-1:0] wr_pri;
   logic [IDX_W-1:0]         tail_idx;
   logic [IDX_W-1:0]         head_next;

   function automatic logic [IDX_W-1:0] to_phys(input logic [IDX_W-1:0] base,
                                                input logic [IDX_W-1:0] ofs);
      logic [IDX_W:0] sum;
      sum = {1'b0, base} + {1'b0, ofs};
      if (sum >= (IDX_W+1)'(CAPACITY)) begin
         sum = sum - (IDX_W+1)'(CAPACITY);
      end
      return sum[IDX_W-1:0];
   endfunction

   assign tail_idx  = IDX_W'(count_ff - 1'b1);
   assign head_next = (head_ff == IDX_W'(CAPACITY - 1)) ? '0 : head_ff + 1'b1;

   assign stat.op_serve = (op_ff == OP_SERVE);
   assign stat.is_empty = (count_ff == '0);
   assign stat.is_full  = (count_ff == CNT_W'(CAPACITY));
   assign stat.cur_zero = (cur_ff == '0);
   // The head only yields to a strictly higher priority; later entries yield on ties.
   assign stat.scan_go  = (cur_ff == '0) ? (rd_pri_ff < new_pri_ff) : (rd_pri_ff <= new_pri_ff);

   always_comb begin
      rd_en   = cmd.rd_head || cmd.rd_tail || cmd.rd_prev;
      rd_addr = head_ff;
      cur_in  = cur_ff;
      if (cmd.rd_tail) begin
         rd_addr = to_phys(head_ff, tail_idx);
         cur_in  = tail_idx;
      end else if (cmd.rd_prev) begin
         rd_addr = to_phys(head_ff, cur_ff - 1'b1);
         cur_in  = cur_ff - 1'b1;
      end
   end

   always_comb begin
      wr_en   = cmd.wr_shift || cmd.wr_new_next || cmd.wr_new_head;
      wr_addr = cmd.wr_new_head ? head_ff : to_phys(head_ff, cur_ff + 1'b1);
      wr_val  = cmd.wr_shift ? rd_val_ff : new_val_ff;
      wr_pri  = cmd.wr_shift ? rd_pri_ff : new_pri_ff;
   end

   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      if (cmd.finish) begin
         if (cmd.fin_status == ST_INSERTED) begin
            count_in = count_ff + 1'b1;
         end else if (cmd.fin_status == ST_SERVED) begin
            count_in = count_ff - 1'b1;
            head_in  = head_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         val_mem_ff[wr_addr] <= wr_val;
         pri_mem_ff[wr_addr] <= wr_pri;
      end
      if (rd_en) begin
         rd_val_ff <= val_mem_ff[rd_addr];
         rd_pri_ff <= pri_mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (cmd.capture) begin
         op_ff      <= req_opcode;
         new_val_ff <= req_item_value;
         new_pri_ff <= req_item_priority;
      end
      if (cmd.finish) begin
         res_status_ff <= cmd.fin_status;
         res_value_ff  <= (cmd.fin_status == ST_SERVED) ? rd_val_ff : '0;
      end
      if (cmd.load_rsp) begin
         rsp_status_ff <= res_status_ff;
         rsp_value_ff  <= res_value_ff;
         rsp_fill_ff   <= FILL_W'(count_ff);
      end
   end

   assign rsp_status       = rsp_status_ff;
   assign rsp_served_value = rsp_value_ff;
   assign rsp_fill_level   = rsp_fill_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("entry count exceeds capacity");

   a_head_bound: assert property (@(posedge clock) disable iff (reset)
      head_ff <= IDX_W'(CAPACITY - 1))
      else $error("head pointer outside the memory");

   a_no_write_full: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (count_ff < CNT_W'(CAPACITY)))
      else $error("memory written while the queue is full");
`endif

endmodule

### rtl/sorted_priority_queue.sv
// Top level of the sorted priority queue: controller and datapath joined by command and status.
//
//   Channel   Direction   Handshake              Payload
//   req       in          req_valid/req_ready    req_opcode, req_item_value, req_item_priority
//   rsp       out         rsp_valid/rsp_ready    rsp_status, rsp_served_value, rsp_fill_level
//
// One request is worked on at a time. A serve goes from transfer to result through capture,
// head read, finish and result load. An insert walks back from the tail one entry per cycle
// through the single registered read port of the entry memory, shifting each entry that
// yields one place back.
// Reset is synchronous and active high; it clears the entry count and head pointer, while the
// entry memory keeps whatever it holds. A new request is taken while an earlier result is still
// waiting on rsp; a finished request waits in its done state until the result register frees.
module sorted_priority_queue import spq_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic                     req_opcode,
   input  logic signed [DATA_W-1:0] req_item_value,
   input  logic signed [DATA_W-1:0] req_item_priority,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [1:0]               rsp_status,
   output logic signed [DATA_W-1:0] rsp_served_value,
   output logic [FILL_W-1:0]        rsp_fill_level
);

   // Command and status groups between the state machine and the datapath.
   dp_cmd_type  cmd;
   dp_stat_type stat;

   // The controller owns the handshakes and decides every memory access and result load.
   spq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // The datapath holds the sorted entries as a circular list, so a serve only moves the head.
   spq_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_opcode        (req_opcode),
      .req_item_value    (req_item_value),
      .req_item_priority (req_item_priority),
      .cmd               (cmd),
      .stat              (stat),
      .rsp_status        (rsp_status),
      .rsp_served_value  (rsp_served_value),
      .rsp_fill_level    (rsp_fill_level)
   );

endmodule

### tb/sorted_priority_queue_tb.sv
// Self-checking testbench for the sorted priority queue under directed and random traffic.
module sorted_priority_queue_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import spq_pkg::*;

   // One pending request. A drain mark is not sent to the block; it makes the
   // sender hold off until every predicted result has been received.
   typedef struct {
      logic                     drain_mark;
      logic                     opcode;
      logic signed [DATA_W-1:0] value;
      logic signed [DATA_W-1:0] prio;
   } queue_req_type;

   typedef struct {
      logic [1:0]               status;
      logic signed [DATA_W-1:0] served;
      logic [FILL_W-1:0]        fill;
   } queue_rsp_type;

   // No transfer at all for this many cycles means the block has hung. The
   // limit leaves a wide margin over the slowest insert and over the stalls
   // that the receiver puts in.
   localparam int STALL_LIMIT  = 2000;
   localparam int RANDOM_ITEMS = 1530;
   localparam int TAIL_CYCLES  = 40;

   logic                     clock             = 1'b0;
   logic                     reset             = 1'b1;
   logic                     req_valid         = 1'b0;
   logic                     req_ready;
   logic                     req_opcode        = OP_INSERT;
   logic signed [DATA_W-1:0] req_item_value    = '0;
   logic signed [DATA_W-1:0] req_item_priority = '0;
   logic                     rsp_valid;
   logic                     rsp_ready         = 1'b0;
   logic [1:0]               rsp_status;
   logic signed [DATA_W-1:0] rsp_served_value;
   logic [FILL_W-1:0]        rsp_fill_level;

   sorted_priority_queue dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_opcode        (req_opcode),
      .req_item_value    (req_item_value),
      .req_item_priority (req_item_priority),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_served_value  (rsp_served_value),
      .rsp_fill_level    (rsp_fill_level)
   );

   always #1 clock = ~clock;

   // Shadow copy of the queue contents, kept sorted with the head at index 0.
   logic signed [DATA_W-1:0] shadow_value [CAPACITY];
   logic signed [DATA_W-1:0] shadow_prio  [CAPACITY];
   int                       shadow_count = 0;

   queue_req_type pending_reqs[$];
   queue_rsp_type predicted_rsps[$];

   int   errors       = 0;
   int   stall_cycles = 0;
   logic req_fire     = 1'b0;
   logic all_quiet    = 1'b0;

   // Sender pacing state.
   logic draining   = 1'b0;
   int   burst_left = 8;
   int   gap_left   = 0;

   // Receiver stall pattern state.
   int   rsp_mode      = 0;
   int   rsp_mode_left = 0;
   int   rsp_phase     = 0;

   // Bookkeeping used only while the stimulus is planned.
   int   plan_fill  = 0;
   int   plan_items = 0;

   // Applies one accepted request to the shadow queue and returns the result
   // the block must give for it.
   function automatic queue_rsp_type predict_queue_op(queue_req_type r);
      queue_rsp_type res;
      int            pos;
      res.served = '0;
      if (r.opcode == OP_INSERT) begin
         if (shadow_count >= CAPACITY) begin
            res.status = ST_FULL;
         end else begin
            // A new entry only takes the head when it strictly beats it; a tie
            // with the head lands right behind it.
            pos = 0;
            if (shadow_count > 0 && r.prio <= shadow_prio[0]) begin
               pos = 1;
               while (pos < shadow_count && r.prio < shadow_prio[pos])
                  pos++;
            end
            for (int i = shadow_count; i > pos; i--) begin
               shadow_value[i] = shadow_value[i-1];
               shadow_prio[i]  = shadow_prio[i-1];
            end
            shadow_value[pos] = r.value;
            shadow_prio[pos]  = r.prio;
            shadow_count++;
            res.status = ST_INSERTED;
         end
      end else begin
         if (shadow_count == 0) begin
            res.status = ST_EMPTY;
         end else begin
            res.served = shadow_value[0];
            shadow_count--;
            for (int i = 0; i < shadow_count; i++) begin
               shadow_value[i] = shadow_value[i+1];
               shadow_prio[i]  = shadow_prio[i+1];
            end
            res.status = ST_SERVED;
         end
      end
      res.fill = FILL_W'(shadow_count);
      return res;
   endfunction

   // Priorities come from four pools: the full range, a narrow band around zero
   // so ties are common, the two range ends plus 0 and -1, and values near the ends.
   function automatic logic signed [DATA_W-1:0] pick_prio();
      logic signed [DATA_W-1:0] p;
      case ($urandom_range(0, 5))
         0, 1: p = $urandom;
         2, 3: p = $urandom_range(0, 6) - 3;
         4: begin
            case ($urandom_range(0, 3))
               0: p = 32'sh7fff_ffff;
               1: p = 32'sh8000_0000;
               2: p = '0;
               default: p = -1;
            endcase
         end
         default: begin
            if ($urandom_range(0, 1))
               p = 32'sh7fff_ffff - $urandom_range(0, 2);
            else
               p = 32'sh8000_0000 + $urandom_range(0, 2);
         end
      endcase
      return p;
   endfunction

   function automatic logic signed [DATA_W-1:0] pick_value();
      logic signed [DATA_W-1:0] v;
      case ($urandom_range(0, 9))
         0: v = 32'sh7fff_ffff;
         1: v = 32'sh8000_0000;
         default: v = $urandom;
      endcase
      return v;
   endfunction

   task automatic plan_insert(logic signed [DATA_W-1:0] v, logic signed [DATA_W-1:0] p);
      queue_req_type r;
      r.drain_mark = 1'b0;
      r.opcode     = OP_INSERT;
      r.value      = v;
      r.prio       = p;
      pending_reqs.push_back(r);
      if (plan_fill < CAPACITY)
         plan_fill++;
      plan_items++;
   endtask

   // The item fields of a serve are ignored by the block, so they carry noise.
   task automatic plan_serve();
      queue_req_type r;
      r.drain_mark = 1'b0;
      r.opcode     = OP_SERVE;
      r.value      = $urandom;
      r.prio       = $urandom;
      pending_reqs.push_back(r);
      if (plan_fill > 0)
         plan_fill--;
      plan_items++;
   endtask

   task automatic plan_drain_pause();
      queue_req_type r;
      r.drain_mark = 1'b1;
      r.opcode     = OP_SERVE;
      r.value      = '0;
      r.prio       = '0;
      pending_reqs.push_back(r);
   endtask

   // Scoreboard: at each rising edge the result transfer is checked against
   // the oldest prediction, and an accepted request is run through the
   // predictor. The watchdog counter and the quiet flag are updated here as
   // well, so that the main sequence reads them at the falling edge.
   always @(posedge clock) begin : scoreboard
      queue_rsp_type want;
      queue_req_type taken;
      req_fire = 1'b0;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (predicted_rsps.size() == 0) begin
               $display("%0t: unexpected result: expected none, got status %0d value %0d fill %0d",
                        $time, rsp_status, rsp_served_value, rsp_fill_level);
               errors++;
            end else begin
               want = predicted_rsps.pop_front();
               if (rsp_status !== want.status) begin
                  $display("%0t: status expected %0d, got %0d", $time, want.status, rsp_status);
                  errors++;
               end
               if (rsp_served_value !== want.served) begin
                  $display("%0t: served_value expected %0d, got %0d",
                           $time, want.served, rsp_served_value);
                  errors++;
               end
               if (rsp_fill_level !== want.fill) begin
                  $display("%0t: fill_level expected %0d, got %0d",
                           $time, want.fill, rsp_fill_level);
                  errors++;
               end
            end
         end
         if (req_valid && req_ready) begin
            req_fire         = 1'b1;
            taken.drain_mark = 1'b0;
            taken.opcode     = req_opcode;
            taken.value      = req_item_value;
            taken.prio       = req_item_priority;
            predicted_rsps.push_back(predict_queue_op(taken));
         end
         if ((rsp_valid && rsp_ready) || req_fire)
            stall_cycles = 0;
         else
            stall_cycles++;
      end
      all_quiet = (pending_reqs.size() == 0) && !req_valid && !draining &&
                  (predicted_rsps.size() == 0);
   end

   // Sender. Requests go out in bursts of random length separated by random
   // gaps; about a third of the gaps are zero so that long back-to-back runs
   // also occur. A request stays on the bus until its transfer.
   always @(negedge clock) begin : sender
      logic          next_valid;
      queue_req_type r;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         next_valid = req_valid && !req_fire;
         if (!next_valid) begin
            if (draining && predicted_rsps.size() == 0)
               draining = 1'b0;
            if (!draining) begin
               if (gap_left > 0) begin
                  gap_left--;
               end else if (pending_reqs.size() > 0) begin
                  r = pending_reqs.pop_front();
                  if (r.drain_mark) begin
                     draining = 1'b1;
                  end else begin
                     req_opcode        <= r.opcode;
                     req_item_value    <= r.value;
                     req_item_priority <= r.prio;
                     next_valid = 1'b1;
                     burst_left--;
                     if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 24);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                     end
                  end
               end
            end
         end
         req_valid <= next_valid;
      end
   end

   // Receiver. It switches between always ready, coin flips, mostly stalled
   // and a fixed duty cycle, each for a stretch of random length.
   always @(negedge clock) begin : receiver
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_mode_left == 0) begin
            rsp_mode      = $urandom_range(0, 3);
            rsp_mode_left = $urandom_range(10, 60);
         end
         rsp_mode_left--;
         rsp_phase++;
         case (rsp_mode)
            0: rsp_ready <= 1'b1;
            1: rsp_ready <= 1'($urandom_range(0, 1));
            2: rsp_ready <= ($urandom_range(0, 3) == 0);
            default: rsp_ready <= ((rsp_phase % 7) < 3);
         endcase
      end
   end

   initial begin : main_sequence
      int  n;
      logic mid_pause_done;
      mid_pause_done = 1'b0;

      // Directed part. A serve on the empty queue comes first, with random
      // item fields that must be ignored.
      plan_serve();
      // Insert into the empty queue: the entry becomes the head.
      plan_insert(32'sd1, 32'sd0);
      // A tie with the head goes behind it.
      plan_insert(32'sh7fff_ffff, 32'sd0);
      // The largest priority takes the head.
      plan_insert(32'sh8000_0000, 32'sh7fff_ffff);
      // The smallest priority goes to the tail.
      plan_insert(-32'sd1, 32'sh8000_0000);
      // A second entry at the largest priority ties with the head.
      plan_insert(32'sd5, 32'sh7fff_ffff);
      plan_insert(32'sd6, -32'sd1);
      plan_insert(32'sd7, 32'sd1);
      // Fill the rest of the queue, then knock on it once it is full.
      while (plan_fill < CAPACITY)
         plan_insert(pick_value(), pick_prio());
      plan_insert(32'sh7fff_ffff, 32'sh7fff_ffff);
      repeat (4) plan_serve();
      // Let everything settle once before the random traffic starts.
      plan_drain_pause();

      // Random part, built from episodes: fill to full and beyond, drain to
      // empty and beyond, hover at a low level, plain coin flips, and runs of
      // near-equal priorities that are then served back out.
      plan_items = 0;
      while (plan_items < RANDOM_ITEMS) begin
         case ($urandom_range(0, 4))
            0: begin
               n = CAPACITY - plan_fill + $urandom_range(0, 2);
               repeat (n) plan_insert(pick_value(), pick_prio());
            end
            1: begin
               n = plan_fill + $urandom_range(0, 2);
               repeat (n) plan_serve();
            end
            2: begin
               repeat ($urandom_range(10, 40)) begin
                  if (plan_fill < 3 || $urandom_range(0, 9) < 4)
                     plan_insert(pick_value(), pick_prio());
                  else
                     plan_serve();
               end
            end
            3: begin
               repeat ($urandom_range(10, 40)) begin
                  if ($urandom_range(0, 1))
                     plan_insert(pick_value(), pick_prio());
                  else
                     plan_serve();
               end
            end
            default: begin
               n = $urandom_range(2, CAPACITY);
               repeat (n) plan_insert(pick_value(), $urandom_range(0, 1));
               repeat (n) plan_serve();
            end
         endcase
         if (!mid_pause_done && plan_items > RANDOM_ITEMS / 2) begin
            plan_drain_pause();
            mid_pause_done = 1'b1;
         end
      end

      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      do
         @(negedge clock);
      while (!all_quiet && stall_cycles < STALL_LIMIT);

      if (stall_cycles >= STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
         $display("sorted_priority_queue: mismatch");
      end else begin
         repeat (TAIL_CYCLES) @(negedge clock);
         if (predicted_rsps.size() != 0) begin
            $display("%0t: %0d results expected, none arrived", $time, predicted_rsps.size());
            errors++;
         end
         if (errors == 0)
            $display("sorted_priority_queue: match");
         else
            $display("sorted_priority_queue: mismatch");
      end
      $finish;
   end

endmodule
